[rtl/heap_placement_engine_macros.svh]
// Assertion macros used by the checker file of the heap placement engine.
`ifndef HEAP_PLACEMENT_ENGINE_MACROS_SVH
`define HEAP_PLACEMENT_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define HPE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("heap placement engine check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define HPE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("heap placement engine check failed");

`endif

[rtl/hpe_pkg.sv]
// Types and constants shared by the heap placement engine modules.
`timescale 1ns / 1ps
package hpe_pkg;

	// Destination table depth; a power of two, the heap counter indexes it by its low bits.
	localparam int TABLE_DEPTH = 256;
	localparam int TBL_AW = $clog2(TABLE_DEPTH);

	// Shared multiplier: 48-bit operands, one byte of b per cycle.
	localparam int MUL_W = 48;
	localparam int MUL_DIG = 8;
	localparam int MUL_STEPS = MUL_W / MUL_DIG;
	localparam int MUL_CW = $clog2(MUL_STEPS);

	// Shared divider: 64-bit dividend, 48-bit divisor, one quotient bit per cycle.
	localparam int DIV_NW = 64;
	localparam int DIV_DW = 48;
	localparam int DIV_CW = $clog2(DIV_NW);

	// Configuration register indexes.
	localparam logic [2:0] CFG_FIRST_FREQ = 3'd0;
	localparam logic [2:0] CFG_FREQ_STEP  = 3'd1;
	localparam logic [2:0] CFG_FREQ_COUNT = 3'd2;
	localparam logic [2:0] CFG_FIRST_ENG  = 3'd3;
	localparam logic [2:0] CFG_ENG_COUNT  = 3'd4;
	localparam logic [2:0] CFG_TSTEP      = 3'd5;
	localparam logic [2:0] CFG_SLOT_BYTES = 3'd6;
	localparam logic [2:0] CFG_TEMP_BYTES = 3'd7;

	// Reset values of the configuration registers.
	localparam logic [31:0] FREQ_STEP_RST  = 32'd1000;
	localparam logic [12:0] FREQ_COUNT_RST = 13'd8;
	localparam logic [10:0] ENG_COUNT_RST  = 11'd64;
	localparam logic [31:0] TSTEP_RST      = 32'd31;
	localparam logic [39:0] TEMP_BYTES_RST = 40'(8 * 64 * 4096 * 2 * 2);

	// Destination codes.
	localparam logic [1:0] TGT_DATA  = 2'd0;
	localparam logic [1:0] TGT_TEMP  = 2'd1;
	localparam logic [1:0] TGT_TRASH = 2'd2;

	// Item kinds.
	localparam logic OP_START = 1'b0;
	localparam logic OP_DONE  = 1'b1;

	typedef enum logic [1:0] {
		MODE_INIT,
		MODE_SEQ,
		MODE_PAR
	} mode_t;

	typedef struct packed {
		logic start;
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic done;
		logic [MUL_W-1:0] p;
	} mul_rsp_t;

	typedef struct packed {
		logic start;
		logic [DIV_NW-1:0] n;
		logic [DIV_DW-1:0] d;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DIV_NW-1:0] q;
	} div_rsp_t;

endpackage

[rtl/hpe_mul.sv]
// Byte-serial multiplier: low 48 bits of a * b.
`timescale 1ns / 1ps
module hpe_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  hpe_pkg::mul_req_t req,
	output hpe_pkg::mul_rsp_t rsp
);
	import hpe_pkg::*;

	logic [MUL_W-1:0] a_q, b_q, acc_q;
	logic [MUL_CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [MUL_W+MUL_DIG-1:0] part;

	assign part = {{MUL_DIG{1'b0}}, a_q} * {{MUL_W{1'b0}}, b_q[MUL_DIG-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MUL_CW'(MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + part[MUL_W-1:0];
			a_q <= a_q << MUL_DIG;
			b_q <= b_q >> MUL_DIG;
		end
	end

	assign rsp.done = done_q;
	assign rsp.p = acc_q;
endmodule

[rtl/hpe_div.sv]
// Restoring divider: 64-bit dividend by nonzero 48-bit divisor, one bit per cycle.
`timescale 1ns / 1ps
module hpe_div (
	input  logic              clk,
	input  logic              arst_n,
	input  hpe_pkg::div_req_t req,
	output hpe_pkg::div_rsp_t rsp
);
	import hpe_pkg::*;

	logic [DIV_NW-1:0] n_q;
	logic [DIV_DW-1:0] d_q, rem_q;
	logic [DIV_CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [DIV_DW:0] trial, diff;
	logic ge;

	assign trial = {rem_q, n_q[DIV_NW-1]};
	assign ge = trial >= {1'b0, d_q};
	assign diff = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bits shift in behind the dividend bits.
	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q <= req.n;
			d_q <= req.d;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
			n_q <= {n_q[DIV_NW-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.q = n_q;
endmodule

[rtl/heap_placement_engine.sv]
// Top level of the heap placement engine: sequencer, state, destination table.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata 184b, tuser opcode
//  m_axis    out  m_axis_tvalid/tready      tdata 48b, tuser target
//  cfg       in   cfg_valid/cfg_ready       cfg_index 3b, cfg_data 48b
//
// Work per accepted word: a start word runs two divides and five multiplies; an early
// one skips the time division. The first start after reset adds two divides and four
// multiplies, or only the four multiplies if time size is 0. A completion multiplies only
// when a full buffer reloads its pending count, and then twice.
// Reset clears all state at once; the destination table clears through valid bits.
// s_axis_tready is high only while idle; a stalled result blocks only the next hand-off.
`timescale 1ns / 1ps
module heap_placement_engine (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// heap_counter[47:0], stamp[95:48], engine_id[111:96], freq_value[159:112],
	// payload_bytes[183:160]
	input  logic [183:0] s_axis_tdata,
	// opcode
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// byte_offset[39:0], too_early[40], too_late[41], slot_full[42], temp_full[43]
	output logic [47:0]  m_axis_tdata,
	// target
	output logic [1:0]   m_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [47:0]  cfg_data
);
	import hpe_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INIT_ECFC,
		S_INIT_TS,
		S_INIT_DSLOT,
		S_INIT_DTEMP,
		S_INIT_PSLOT,
		S_INIT_PTEMP,
		S_FS,
		S_TS,
		S_IDX,
		S_CLASS,
		S_OFF_T,
		S_OFF_E,
		S_FDIV,
		S_OFF_F,
		S_TBL,
		S_C_READ,
		S_C_UPD,
		S_C_ECFC,
		S_C_SPACE,
		S_EMIT
	} st_t;

	st_t state_q;

	// configuration
	logic [47:0] ff_q;
	logic [31:0] fstep_q, tstep_q;
	logic [12:0] fc_q;
	logic [15:0] fe_q;
	logic [10:0] ec_q;
	logic [39:0] sbytes_q, tbytes_q;

	// block state
	mode_t mode_q;
	logic [23:0] hb_q;
	logic [39:0] scap_q, tcap_q, spend_q, tpend_q;
	logic [47:0] sfs_q, tfs_q;

	// item and work registers
	logic [TBL_AW-1:0] addr_q;
	logic [47:0] stamp_q, freq_q;
	logic [15:0] eng_q;
	logic [23:0] pay_q;
	logic [47:0] ecfc_q, ts_q, fs_q;
	logic [49:0] idx_q;
	logic [1:0] tgt_q;
	logic early_q, late_q, sfull_q, tfull_q, which_slot_q, issued_q;
	logic [39:0] off_q;

	// output register
	logic m_valid_q;
	logic [47:0] m_data_q;
	logic [1:0] m_user_q;

	// destination table
	logic [1:0] tbl_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] tbl_vld_q;
	logic [1:0] tbl_rd_s1;
	logic tbl_vld_s1;

	mul_req_t mul_req;
	mul_rsp_t mul_rsp;
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [31:0] tstep1, fstep1;
	logic [49:0] num;
	logic [63:0] fnum;
	logic [16:0] edif;
	logic [40:0] cap_sum;
	logic [1:0] entry;
	logic [39:0] sp_dec, tp_dec;
	logic use_mul, use_div, s_acc;

	hpe_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));
	hpe_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	assign tstep1 = (tstep_q == '0) ? 32'd1 : tstep_q;
	assign fstep1 = (fstep_q == '0) ? 32'd1 : fstep_q;
	assign num = {2'b00, stamp_q} - {2'b00, sfs_q} + {19'd0, tstep1[31:1]};
	assign fnum = {16'd0, freq_q} - {16'd0, ff_q} + {33'd0, fstep1[31:1]};
	assign edif = {1'b0, eng_q} - {1'b0, fe_q};
	assign cap_sum = {1'b0, scap_q} + {1'b0, tcap_q};
	assign entry = tbl_vld_s1 ? tbl_rd_s1 : TGT_DATA;
	assign sp_dec = (entry == TGT_DATA) ? spend_q - 40'd1 : spend_q;
	assign tp_dec = (entry == TGT_TEMP) ? tpend_q - 40'd1 : tpend_q;
	assign s_acc = s_axis_tvalid && s_axis_tready;

	// Operand selection for the shared units.
	always_comb begin
		use_mul = 1'b0;
		use_div = 1'b0;
		mul_req.a = '0;
		mul_req.b = '0;
		div_req.n = '0;
		div_req.d = '0;
		unique case (state_q)
			S_INIT_ECFC, S_C_ECFC: begin
				use_mul = 1'b1;
				mul_req.a = {37'd0, ec_q};
				mul_req.b = {35'd0, fc_q};
			end
			S_INIT_TS: begin
				use_mul = 1'b1;
				mul_req.a = ecfc_q;
				mul_req.b = {24'd0, pay_q};
			end
			S_INIT_DSLOT: begin
				use_div = 1'b1;
				div_req.n = {24'd0, sbytes_q};
				div_req.d = ts_q;
			end
			S_INIT_DTEMP: begin
				use_div = 1'b1;
				div_req.n = {24'd0, tbytes_q};
				div_req.d = ts_q;
			end
			S_INIT_PSLOT: begin
				use_mul = 1'b1;
				mul_req.a = {8'd0, scap_q};
				mul_req.b = ecfc_q;
			end
			S_INIT_PTEMP: begin
				use_mul = 1'b1;
				mul_req.a = {8'd0, tcap_q};
				mul_req.b = ecfc_q;
			end
			S_C_SPACE: begin
				use_mul = 1'b1;
				mul_req.a = which_slot_q ? {8'd0, scap_q} : {8'd0, tcap_q};
				mul_req.b = ecfc_q;
			end
			S_FS: begin
				use_mul = 1'b1;
				mul_req.a = {35'd0, fc_q};
				mul_req.b = {24'd0, hb_q};
			end
			S_TS: begin
				use_mul = 1'b1;
				mul_req.a = {37'd0, ec_q};
				mul_req.b = fs_q;
			end
			S_IDX: begin
				use_div = !num[49];
				div_req.n = {14'd0, num};
				div_req.d = {16'd0, tstep1};
			end
			S_OFF_T: begin
				use_mul = 1'b1;
				mul_req.a = ts_q;
				mul_req.b = idx_q[47:0];
			end
			S_OFF_E: begin
				use_mul = 1'b1;
				mul_req.a = fs_q;
				mul_req.b = {{31{edif[16]}}, edif};
			end
			S_FDIV: begin
				use_div = 1'b1;
				div_req.n = fnum;
				div_req.d = {16'd0, fstep1};
			end
			S_OFF_F: begin
				use_mul = 1'b1;
				mul_req.a = {24'd0, hb_q};
				mul_req.b = idx_q[47:0];
			end
			default: begin
				use_mul = 1'b0;
				use_div = 1'b0;
			end
		endcase
		mul_req.start = use_mul && !issued_q;
		div_req.start = use_div && !issued_q;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_TBL) begin
			tbl_mem[addr_q] <= tgt_q;
		end
		tbl_rd_s1 <= tbl_mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ff_q <= '0;
			fstep_q <= FREQ_STEP_RST;
			fc_q <= FREQ_COUNT_RST;
			fe_q <= '0;
			ec_q <= ENG_COUNT_RST;
			tstep_q <= TSTEP_RST;
			sbytes_q <= '0;
			tbytes_q <= TEMP_BYTES_RST;
			mode_q <= MODE_INIT;
			hb_q <= '0;
			scap_q <= '0;
			tcap_q <= '0;
			spend_q <= '0;
			tpend_q <= '0;
			sfs_q <= '0;
			tfs_q <= '0;
			tbl_vld_q <= '0;
			tbl_vld_s1 <= 1'b0;
			issued_q <= 1'b0;
			m_valid_q <= 1'b0;
			m_data_q <= '0;
			m_user_q <= TGT_DATA;
			addr_q <= '0;
			stamp_q <= '0;
			freq_q <= '0;
			eng_q <= '0;
			pay_q <= '0;
			ecfc_q <= '0;
			ts_q <= '0;
			fs_q <= '0;
			idx_q <= '0;
			tgt_q <= TGT_DATA;
			early_q <= 1'b0;
			late_q <= 1'b0;
			sfull_q <= 1'b0;
			tfull_q <= 1'b0;
			which_slot_q <= 1'b0;
			off_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_FIRST_FREQ: ff_q <= cfg_data;
					CFG_FREQ_STEP:  fstep_q <= cfg_data[31:0];
					CFG_FREQ_COUNT: fc_q <= cfg_data[12:0];
					CFG_FIRST_ENG:  fe_q <= cfg_data[15:0];
					CFG_ENG_COUNT:  ec_q <= cfg_data[10:0];
					CFG_TSTEP:      tstep_q <= cfg_data[31:0];
					CFG_SLOT_BYTES: sbytes_q <= cfg_data[39:0];
					CFG_TEMP_BYTES: tbytes_q <= cfg_data[39:0];
					default: ;
				endcase
			end

			// drop a taken word unless the next one replaces it
			if (m_valid_q && m_axis_tready && state_q != S_EMIT) begin
				m_valid_q <= 1'b0;
			end

			if (mul_req.start || div_req.start) begin
				issued_q <= 1'b1;
			end else if (mul_rsp.done || div_rsp.done) begin
				issued_q <= 1'b0;
			end

			tbl_vld_s1 <= tbl_vld_q[addr_q];

			unique case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						addr_q <= s_axis_tdata[TBL_AW-1:0];
						stamp_q <= s_axis_tdata[95:48];
						eng_q <= s_axis_tdata[111:96];
						freq_q <= s_axis_tdata[159:112];
						pay_q <= s_axis_tdata[183:160];
						tgt_q <= TGT_DATA;
						off_q <= '0;
						idx_q <= '0;
						early_q <= 1'b0;
						late_q <= 1'b0;
						sfull_q <= 1'b0;
						tfull_q <= 1'b0;
						if (s_axis_tuser == OP_DONE) begin
							// completions before the first start answer zero
							state_q <= (mode_q == MODE_INIT) ? S_EMIT : S_C_READ;
						end else begin
							state_q <= (mode_q == MODE_INIT) ? S_INIT_ECFC : S_FS;
						end
					end
				end
				S_INIT_ECFC: begin
					if (mul_rsp.done) begin
						ecfc_q <= mul_rsp.p;
						state_q <= S_INIT_TS;
					end
				end
				S_INIT_TS: begin
					if (mul_rsp.done) begin
						ts_q <= mul_rsp.p;
						if (mul_rsp.p == '0) begin
							scap_q <= '0;
							tcap_q <= '0;
							state_q <= S_INIT_PSLOT;
						end else begin
							state_q <= S_INIT_DSLOT;
						end
					end
				end
				S_INIT_DSLOT: begin
					if (div_rsp.done) begin
						scap_q <= div_rsp.q[39:0];
						state_q <= S_INIT_DTEMP;
					end
				end
				S_INIT_DTEMP: begin
					if (div_rsp.done) begin
						tcap_q <= div_rsp.q[39:0];
						state_q <= S_INIT_PSLOT;
					end
				end
				S_INIT_PSLOT: begin
					if (mul_rsp.done) begin
						spend_q <= mul_rsp.p[39:0];
						state_q <= S_INIT_PTEMP;
					end
				end
				S_INIT_PTEMP: begin
					if (mul_rsp.done) begin
						tpend_q <= mul_rsp.p[39:0];
						hb_q <= pay_q;
						sfs_q <= stamp_q;
						mode_q <= MODE_SEQ;
						state_q <= S_FS;
					end
				end
				S_FS: begin
					if (mul_rsp.done) begin
						fs_q <= mul_rsp.p;
						state_q <= S_TS;
					end
				end
				S_TS: begin
					if (mul_rsp.done) begin
						ts_q <= mul_rsp.p;
						state_q <= S_IDX;
					end
				end
				S_IDX: begin
					if (num[49]) begin
						tgt_q <= TGT_TRASH;
						early_q <= 1'b1;
						idx_q <= '0;
						state_q <= S_OFF_T;
					end else if (div_rsp.done) begin
						idx_q <= div_rsp.q[49:0];
						state_q <= S_CLASS;
					end
				end
				S_CLASS: begin
					state_q <= S_OFF_T;
					if (mode_q == MODE_PAR) begin
						if (idx_q >= {10'd0, scap_q}) begin
							tgt_q <= TGT_TRASH;
							late_q <= 1'b1;
							idx_q <= '0;
						end else if (idx_q < {10'd0, tcap_q}) begin
							tgt_q <= TGT_TEMP;
						end else begin
							tgt_q <= TGT_DATA;
						end
					end else begin
						if (idx_q >= {9'd0, cap_sum}) begin
							tgt_q <= TGT_TRASH;
							late_q <= 1'b1;
							idx_q <= '0;
						end else if (idx_q < {10'd0, scap_q}) begin
							tgt_q <= TGT_DATA;
						end else begin
							// track the earliest stamp that spills into temp
							if (tfs_q == '0 || tfs_q > stamp_q) begin
								tfs_q <= stamp_q;
							end
							tgt_q <= TGT_TEMP;
							idx_q <= idx_q - {10'd0, scap_q};
						end
					end
				end
				S_OFF_T: begin
					if (mul_rsp.done) begin
						off_q <= mul_rsp.p[39:0];
						state_q <= S_OFF_E;
					end
				end
				S_OFF_E: begin
					if (mul_rsp.done) begin
						off_q <= off_q + mul_rsp.p[39:0];
						state_q <= S_FDIV;
					end
				end
				S_FDIV: begin
					if (div_rsp.done) begin
						idx_q <= div_rsp.q[49:0];
						state_q <= S_OFF_F;
					end
				end
				S_OFF_F: begin
					if (mul_rsp.done) begin
						off_q <= off_q + mul_rsp.p[39:0];
						state_q <= S_TBL;
					end
				end
				S_TBL: begin
					tbl_vld_q[addr_q] <= 1'b1;
					state_q <= S_EMIT;
				end
				S_C_READ: begin
					state_q <= S_C_UPD;
				end
				S_C_UPD: begin
					tgt_q <= entry;
					tbl_vld_q[addr_q] <= 1'b0;
					spend_q <= sp_dec;
					tpend_q <= tp_dec;
					if (sp_dec == '0) begin
						which_slot_q <= 1'b1;
						state_q <= S_C_ECFC;
					end else if (tp_dec == '0) begin
						which_slot_q <= 1'b0;
						state_q <= S_C_ECFC;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_C_ECFC: begin
					if (mul_rsp.done) begin
						ecfc_q <= mul_rsp.p;
						state_q <= S_C_SPACE;
					end
				end
				S_C_SPACE: begin
					if (mul_rsp.done) begin
						if (which_slot_q) begin
							spend_q <= mul_rsp.p[39:0];
							sfs_q <= tfs_q;
							mode_q <= MODE_PAR;
							sfull_q <= 1'b1;
						end else begin
							tpend_q <= mul_rsp.p[39:0];
							tfs_q <= '0;
							spend_q <= spend_q - mul_rsp.p[39:0];
							mode_q <= MODE_SEQ;
							tfull_q <= 1'b1;
						end
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					// hand over once the output register is free
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_user_q <= tgt_q;
						m_data_q <= {4'd0, tfull_q, sfull_q, late_q, early_q, off_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;
	assign m_axis_tuser = m_user_q;
	assign cfg_ready = 1'b1;
endmodule

[rtl/hpe_checker.sv]
// Port-level checks of the heap placement engine, bound to the top level.
`timescale 1ns / 1ps
`include "heap_placement_engine_macros.svh"
module hpe_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [47:0]  m_axis_tdata,
	input logic [1:0]   m_axis_tuser
);
	import hpe_pkg::*;

	logic m_stall, m_odd, m_full;
	logic [49:0] m_word;

	assign m_stall = m_axis_tvalid && !m_axis_tready;
	assign m_word = {m_axis_tuser, m_axis_tdata};
	assign m_odd = m_axis_tvalid && (m_axis_tdata[40] || m_axis_tdata[41]);
	assign m_full = m_axis_tvalid && (m_axis_tdata[42] || m_axis_tdata[43]);

	// a stalled result word holds
	`HPE_ASSERT_NXT(a_out_hold, m_stall, m_axis_tvalid && $stable(m_word))
	// the engine works on one word at a time
	`HPE_ASSERT_NXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// no destination code beyond trash
	`HPE_ASSERT_IMP(a_target, m_axis_tvalid, m_axis_tuser <= TGT_TRASH)
	// early or late words go to trash, never both flagged
	`HPE_ASSERT_IMP(a_trash, m_odd, m_axis_tuser == TGT_TRASH && !(&m_axis_tdata[41:40]))
	// one full flag at most, and never beside an early or late flag
	`HPE_ASSERT_IMP(a_full, m_full, !(&m_axis_tdata[43:42]) && m_axis_tdata[41:40] == 2'b00)
endmodule

bind heap_placement_engine hpe_checker u_hpe_checker (.*);
